FILE: rtl/assert_macros.svh
// Assertion macros for the checker file aesks_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define AESKS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// Clocked check that also holds during reset.
`define AESKS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");

`endif

FILE: rtl/aesks_pkg.sv
// Types, constants and lookup functions for the AES-128 key schedule.
// No dependencies.
package aesks_pkg;

  localparam int unsigned RoundW    = 4;
  localparam int unsigned NumRounds = 11;
  localparam logic [RoundW-1:0] LastRound = RoundW'(NumRounds - 1);

  typedef enum logic {
    KS_IDLE,
    KS_RUN
  } ks_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;  // take a new cipher key, round 0
    logic step;  // compute the next round key
  } ks_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;  // round 10 is in the output register
  } ks_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constant used to go from round r to round r+1.
  function automatic logic [7:0] rcon_f(logic [RoundW-1:0] r);
    logic [7:0] rc;
    unique case (r)
      4'd0:    rc = 8'h01;
      4'd1:    rc = 8'h02;
      4'd2:    rc = 8'h04;
      4'd3:    rc = 8'h08;
      4'd4:    rc = 8'h10;
      4'd5:    rc = 8'h20;
      4'd6:    rc = 8'h40;
      4'd7:    rc = 8'h80;
      4'd8:    rc = 8'h1B;
      4'd9:    rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  function automatic logic [31:0] sub_word_f(logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

FILE: rtl/aesks_datapath.sv
// Round key register, round counter and the shared round-key step.
// Depends on aesks_pkg.
module aesks_datapath
  import aesks_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ks_cmd_t           cmd_i,
  input  logic [63:0]       key_high_i,
  input  logic [63:0]       key_low_i,
  output ks_status_t        status_o,
  output logic [RoundW-1:0] round_index_o,
  output logic [63:0]       round_key_high_o,
  output logic [63:0]       round_key_low_o,
  output logic              last_round_o
);

  logic [127:0]      key_q, key_d;
  logic [RoundW-1:0] round_q, round_d;

  logic [31:0] rot_w, tmp_w;
  logic [31:0] n0, n1, n2, n3;

  // RotWord, SubWord and rcon on word 3, then XOR forward.
  always_comb begin
    rot_w = {key_q[23:0], key_q[31:24]};
    tmp_w = sub_word_f(rot_w) ^ {rcon_f(round_q), 24'h000000};
    n0    = key_q[127:96] ^ tmp_w;
    n1    = key_q[95:64]  ^ n0;
    n2    = key_q[63:32]  ^ n1;
    n3    = key_q[31:0]   ^ n2;
  end

  always_comb begin
    key_d   = key_q;
    round_d = round_q;
    if (cmd_i.load) begin
      key_d   = {key_high_i, key_low_i};
      round_d = '0;
    end else if (cmd_i.step) begin
      key_d   = {n0, n1, n2, n3};
      round_d = round_q + RoundW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      round_q <= '0;
    end else begin
      key_q   <= key_d;
      round_q <= round_d;
    end
  end

  assign status_o.last    = (round_q == LastRound);
  assign round_index_o    = round_q;
  assign round_key_high_o = key_q[127:64];
  assign round_key_low_o  = key_q[63:0];
  assign last_round_o     = (round_q == LastRound);

endmodule

FILE: rtl/aesks_ctrl.sv
// Controller for the key schedule: handshakes and load/step commands.
// Depends on aesks_pkg.
module aesks_ctrl
  import aesks_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_stall_i,
  input  ks_status_t status_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output ks_cmd_t    cmd_o
);

  ks_state_e state_q, state_d;
  logic      out_acc;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      KS_IDLE: begin
        if (in_valid_i) state_d = KS_RUN;
      end
      KS_RUN: begin
        if (!out_stall_i && status_i.last && !in_valid_i) state_d = KS_IDLE;
      end
      default: state_d = KS_IDLE;
    endcase
  end

  // A new key may load in the cycle the final round word leaves.
  always_comb begin
    out_valid_o = (state_q == KS_RUN);
    out_acc     = out_valid_o && !out_stall_i;
    in_stall_o  = (state_q == KS_RUN) && !(out_acc && status_i.last);
    cmd_o.load  = in_valid_i && !in_stall_o;
    cmd_o.step  = out_acc && !status_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/aes128_key_schedule.sv
// AES-128 key schedule, top level.
// Depends on aesks_pkg, aesks_ctrl and aesks_datapath.
//
// One 128-bit cipher key in, eleven round key words out (round 0 = the key,
// round 10 flagged by last_round_o). An accepted key appears as round 0 on
// the next cycle; each further round is computed by the single round-key
// step (four S-box lookups and an XOR chain) and registered once the
// previous word is taken. The input is stalled while a key is being
// expanded; the next key is taken in the same cycle its predecessor's
// round 10 word is taken.
module aes128_key_schedule
  import aesks_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [63:0]       key_high_i,
  input  logic [63:0]       key_low_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [RoundW-1:0] round_index_o,
  output logic [63:0]       round_key_high_o,
  output logic [63:0]       round_key_low_o,
  output logic              last_round_o
);

  ks_cmd_t    cmd;
  ks_status_t status;

  aesks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .cmd_o      (cmd)
  );

  aesks_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .key_high_i      (key_high_i),
    .key_low_i       (key_low_i),
    .status_o        (status),
    .round_index_o   (round_index_o),
    .round_key_high_o(round_key_high_o),
    .round_key_low_o (round_key_low_o),
    .last_round_o    (last_round_o)
  );

endmodule

FILE: rtl/aesks_checker.sv
// Port-level checks for aes128_key_schedule, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module aesks_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [63:0] key_high_i,
  input logic [63:0] key_low_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  round_index_o,
  input logic [63:0] round_key_high_o,
  input logic [63:0] round_key_low_o,
  input logic        last_round_o
);

  // A taken key comes back unchanged as round 0.
  `AESKS_ASSERT(a_key_to_round0, in_valid_i && !in_stall_o |=> out_valid_o && round_index_o == 4'd0 && round_key_high_o == $past(key_high_i) && round_key_low_o == $past(key_low_i))

  // Rounds follow each other without gaps until the last.
  `AESKS_ASSERT(a_round_seq, out_valid_o && !out_stall_i && !last_round_o |=> out_valid_o && round_index_o == $past(round_index_o) + 4'd1)

  // Last flag marks round 10 exactly.
  `AESKS_ASSERT(a_last_flag, out_valid_o |-> last_round_o == (round_index_o == 4'd10))

  // A stalled word holds.
  `AESKS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(round_key_high_o) && $stable(round_key_low_o) && $stable(round_index_o))

endmodule

bind aes128_key_schedule aesks_checker u_aesks_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .key_high_i      (key_high_i),
  .key_low_i       (key_low_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .round_index_o   (round_index_o),
  .round_key_high_o(round_key_high_o),
  .round_key_low_o (round_key_low_o),
  .last_round_o    (last_round_o)
);

FILE: dv/aes128_key_schedule_checker.sv
`timescale 1ns / 100ps
// Checker for the AES-128 key schedule: watches both channels, predicts the
// eleven round key words per key and compares them in order.
// Depends on aesks_pkg for RoundW and NumRounds.
module aes128_key_schedule_checker
  import aesks_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [63:0]       key_high_i,
  input  logic [63:0]       key_low_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [RoundW-1:0] round_index_i,
  input  logic [63:0]       round_key_high_i,
  input  logic [63:0]       round_key_low_i,
  input  logic              last_round_i,
  output int                errors_o,
  output int                pending_o,
  output int                keys_o,
  output int                words_o
);

  typedef struct packed {
    logic [RoundW-1:0] idx;
    logic [63:0]       hi;
    logic [63:0]       lo;
    logic              last;
  } round_word_t;

  logic [7:0]  sub_lut [256];
  round_word_t round_key_q [$];
  round_word_t held_word;
  logic        held = 1'b0;

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xtime(a);
    end
    return p;
  endfunction

  function automatic logic [127:0] next_round_key(logic [127:0] k, logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {k[23:0], k[31:24]};
    t  = {sub_lut[t[31:24]], sub_lut[t[23:16]], sub_lut[t[15:8]], sub_lut[t[7:0]]}
         ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  task automatic queue_round_keys(input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] k;
    logic [7:0]   rc;
    round_word_t  w;
    k  = {hi, lo};
    rc = 8'h01;
    for (int r = 0; r < NumRounds; r++) begin
      if (r > 0) begin
        k  = next_round_key(k, rc);
        rc = xtime(rc);
      end
      w.idx  = RoundW'(r);
      w.hi   = k[127:64];
      w.lo   = k[63:0];
      w.last = (r == NumRounds - 1);
      round_key_q.push_back(w);
    end
  endtask

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
      errors_o++;
    end
  endtask

  // S-box from the field inverse plus the affine map; known-answer check after.
  initial begin
    logic [7:0]   inv;
    logic [15:0]  dbl;
    logic [127:0] k;
    logic [7:0]   rc;
    for (int v = 0; v < 256; v++) begin
      inv = 8'h01;
      repeat (254) inv = gf_mul(inv, 8'(v));
      dbl = {inv, inv};
      sub_lut[v] = inv ^ dbl[14:7] ^ dbl[13:6] ^ dbl[12:5] ^ dbl[11:4] ^ 8'h63;
    end
    k  = 128'h2b7e151628aed2a6abf7158809cf4f3c;
    rc = 8'h01;
    repeat (10) begin
      k  = next_round_key(k, rc);
      rc = xtime(rc);
    end
    if (k !== 128'hd014f9a8c9ee2589e13f0cc8b6630ca6) begin
      $display("%0t: predictor known-answer, expected %h got %h", $time,
               128'hd014f9a8c9ee2589e13f0cc8b6630ca6, k);
      errors_o++;
    end
  end

  always @(posedge clk_i) begin
    round_word_t seen, want;
    if (rst_ni) begin
      seen = {round_index_i, round_key_high_i, round_key_low_i, last_round_i};
      // a stalled output word must stay put
      if (held && (!out_valid_i || seen !== held_word)) begin
        $display("%0t: stalled word changed, expected %h got %h", $time, held_word, seen);
        errors_o++;
      end
      held      = out_valid_i && out_stall_i;
      held_word = seen;

      if (in_valid_i && !in_stall_i) begin
        queue_round_keys(key_high_i, key_low_i);
        keys_o++;
      end

      if (out_valid_i && !out_stall_i) begin
        words_o++;
        if (round_key_q.size() == 0) begin
          $display("%0t: unexpected word, expected none got %h", $time, seen);
          errors_o++;
        end else begin
          want = round_key_q.pop_front();
          compare_field("round_index", 64'(want.idx), 64'(round_index_i));
          compare_field("round_key_high", want.hi, round_key_high_i);
          compare_field("round_key_low", want.lo, round_key_low_i);
          compare_field("last_round", 64'(want.last), 64'(last_round_i));
        end
      end
      pending_o = round_key_q.size();
    end
  end

endmodule

FILE: dv/tb_aes128_key_schedule.sv
`timescale 1ns / 100ps
// Top of the AES-128 key schedule testbench: clock, reset, key stimulus,
// output stalls and the verdict. Depends on aesks_pkg, aes128_key_schedule
// and aes128_key_schedule_checker.
module tb_aes128_key_schedule;
  import aesks_pkg::*;

  localparam int HoldCycles   = 200;
  localparam int WatchdogMax  = 2000;
  localparam int PhaseKeys    = 42;
  localparam int SendIdle [4] = '{0, 59, 0, 24};
  localparam int RecvStall [4] = '{0, 0, 59, 24};
  localparam logic [127:0] DirectedKeys [12] = '{
    128'h0,
    {128{1'b1}},
    128'h2b7e151628aed2a6abf7158809cf4f3c,
    128'h000102030405060708090a0b0c0d0e0f,
    128'h5555555555555555aaaaaaaaaaaaaaaa,
    128'haaaaaaaaaaaaaaaa5555555555555555,
    {64'h0, 64'hffffffffffffffff},
    {64'hffffffffffffffff, 64'h0},
    128'h80000000000000000000000000000001,
    128'h00000000000000018000000000000000,
    128'h0123456789abcdeffedcba9876543210,
    128'h0
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [63:0]       key_high_i;
  logic [63:0]       key_low_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [RoundW-1:0] round_index_o;
  logic [63:0]       round_key_high_o;
  logic [63:0]       round_key_low_o;
  logic              last_round_o;

  int errors, pending, keys_seen, words_seen;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  bit hold_request   = 1'b0;

  always #4 clk_i = ~clk_i;

  aes128_key_schedule dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .key_high_i,
    .key_low_i,
    .out_valid_o,
    .out_stall_i,
    .round_index_o,
    .round_key_high_o,
    .round_key_low_o,
    .last_round_o
  );

  aes128_key_schedule_checker checker_i (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i       (in_stall_o),
    .key_high_i,
    .key_low_i,
    .out_valid_i      (out_valid_o),
    .out_stall_i,
    .round_index_i    (round_index_o),
    .round_key_high_i (round_key_high_o),
    .round_key_low_i  (round_key_low_o),
    .last_round_i     (last_round_o),
    .errors_o         (errors),
    .pending_o        (pending),
    .keys_o           (keys_seen),
    .words_o          (words_seen)
  );

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        for (int n = 0; n < HoldCycles; n++) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogMax) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_key(input logic [63:0] hi, input logic [63:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_high_i <= hi;
    key_low_i  <= lo;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  function automatic void make_key(output logic [63:0] hi, output logic [63:0] lo);
    hi = {$urandom, $urandom};
    lo = {$urandom, $urandom};
    case ($urandom_range(9))
      0: hi = '0;
      1: lo = '1;
      2: begin
        hi = 64'd1 << $urandom_range(63);
        lo = 64'd1 << $urandom_range(63);
      end
      default: ;
    endcase
  endfunction

  initial begin
    logic [63:0] hi, lo;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    key_high_i = '0;
    key_low_i  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed keys back to back, no idling
    foreach (DirectedKeys[i]) send_key(DirectedKeys[i][127:64], DirectedKeys[i][63:0]);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = SendIdle[ph];
      recv_stall_pct = RecvStall[ph];
      for (int n = 0; n < PhaseKeys; n++) begin
        // long output hold-off while keys keep coming
        if (ph == 0 && n == 10) hold_request = 1'b1;
        make_key(hi, lo);
        send_key(hi, lo);
      end
      drain_results();
    end

    repeat (30) @(posedge clk_i);
    $display("Expanded %0d keys into %0d round key words under four idle/stall mixes,",
             keys_seen, words_seen);
    $display("including a %0d-cycle output hold-off and full drains.", HoldCycles);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/aesks_pkg.sv
rtl/aesks_datapath.sv
rtl/aesks_ctrl.sv
rtl/aes128_key_schedule.sv
rtl/aesks_checker.sv
dv/aes128_key_schedule_checker.sv
dv/tb_aes128_key_schedule.sv
